// ===== design/bcf_pkg.sv =====
// Shared types, constants and the CRC fold function of the block CRC body framer.
`timescale 1ns / 1ps

package bcf_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned FILL_W = 4;
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA6BC;

    // One body byte after classification, waiting for the output side.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              emit;
        logic              last;
        logic [CRC_W-1:0]  chk;
    } t_item;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Folds one byte into a reflected CRC-16, one bit per step.
    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc,
        input logic [DATA_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-DATA_W){1'b0}}, b};
        for (int i = 0; i < DATA_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/bcf_front.sv =====
// Input side: accepts bytes, updates the running CRC and block count, queues the item.
`timescale 1ns / 1ps

module bcf_front #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bcf_pkg::DATA_W-1:0]   i_data_byte,
    input  logic                         i_last_byte,
    input  bcf_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output bcf_pkg::t_item               o_item
);

    localparam logic [bcf_pkg::FILL_W:0] BLK_SIZE = (bcf_pkg::FILL_W + 1)'(BLOCK_BYTES);

    logic [bcf_pkg::CRC_W-1:0]  r_crc;
    logic [bcf_pkg::CRC_W-1:0]  n_crc;
    logic [bcf_pkg::FILL_W-1:0] r_fill;
    logic [bcf_pkg::FILL_W-1:0] n_fill;
    logic [bcf_pkg::FILL_W:0]   count;
    logic [bcf_pkg::CRC_W-1:0]  crc_new;
    logic                       emit;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    assign count   = {1'b0, r_fill} + 1'b1;
    assign emit    = i_last_byte || (count >= BLK_SIZE);
    assign crc_new = bcf_pkg::crc_fold(r_crc, i_data_byte);

    always_comb begin
        o_item.data = i_data_byte;
        o_item.emit = emit;
        o_item.last = i_last_byte;
        o_item.chk  = ~crc_new;
    end

    always_comb begin
        n_crc  = r_crc;
        n_fill = r_fill;
        if (o_push) begin
            if (emit) begin
                n_crc  = '0;
                n_fill = '0;
            end else begin
                n_crc  = crc_new;
                n_fill = count[bcf_pkg::FILL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_fill <= '0;
        end else begin
            r_crc  <= n_crc;
            r_fill <= n_fill;
        end
    end

endmodule

// ===== design/bcf_queue.sv =====
// Short queue of classified items between the input and output sides.
`timescale 1ns / 1ps

module bcf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bcf_pkg::t_item     i_item,
    input  logic               i_pop,
    output bcf_pkg::t_item     o_head,
    output bcf_pkg::t_q_status o_status
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    bcf_pkg::t_item     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               do_pop;

    assign o_status.full  = (r_count == (PTR_W + 1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/bcf_back.sv =====
// Output side: sends the data byte and, where due, the two check bytes of each item.
`timescale 1ns / 1ps

module bcf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bcf_pkg::t_item             i_head,
    input  bcf_pkg::t_q_status         i_q_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bcf_pkg::DATA_W-1:0] o_out_byte,
    output logic                       o_is_check_byte,
    output logic                       o_run_last,
    output logic                       o_frame_last
);

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    t_phase r_phase;
    logic   r_valid;
    logic   load;

    // The output register takes a new transfer when it is empty or being drained.
    assign load    = !i_q_status.empty && (!r_valid || !i_stall);
    assign o_pop   = load && ((r_phase == PH_CRC_HI) || ((r_phase == PH_DATA) && !i_head.emit));
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                case (r_phase)
                    PH_DATA: begin
                        o_out_byte      <= i_head.data;
                        o_is_check_byte <= 1'b0;
                        o_run_last      <= !i_head.emit;
                        o_frame_last    <= 1'b0;
                        r_phase         <= i_head.emit ? PH_CRC_LO : PH_DATA;
                    end
                    PH_CRC_LO: begin
                        o_out_byte      <= i_head.chk[bcf_pkg::DATA_W-1:0];
                        o_is_check_byte <= 1'b1;
                        o_run_last      <= 1'b0;
                        o_frame_last    <= 1'b0;
                        r_phase         <= PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        o_out_byte      <= i_head.chk[bcf_pkg::CRC_W-1:bcf_pkg::DATA_W];
                        o_is_check_byte <= 1'b1;
                        o_run_last      <= 1'b1;
                        o_frame_last    <= i_head.last;
                        r_phase         <= PH_DATA;
                    end
                    default: begin
                        r_phase <= PH_DATA;
                    end
                endcase
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/block_crc_body_framer.sv =====
// Top level of the block CRC body framer: input side, item queue and output side.
`timescale 1ns / 1ps
// A byte accepted at the input is written into the queue, then loaded into the output register.
// Throughput: one input transfer per cycle while the queue is not full; a byte that
// closes a block or a frame goes out on the single output port as data, CRC low
// and CRC high. The four-entry queue absorbs the check bytes before the input stalls.
// Reset (synchronous, active low) clears the CRC, block count, queue and output valid.

module block_crc_body_framer #(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel: one body byte per transfer.
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bcf_pkg::DATA_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    // Output channel: one data or check byte per transfer.
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bcf_pkg::DATA_W-1:0] o_out_byte,
    output logic                       o_is_check_byte,
    output logic                       o_run_last,
    output logic                       o_frame_last
);

    bcf_pkg::t_item     push_item;
    bcf_pkg::t_item     head_item;
    bcf_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    // The input side folds each byte into the CRC as it is accepted and decides
    // whether the byte closes a block, so the queued item already carries the
    // complemented check value that the output side needs.
    bcf_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    // The queue lets the input side keep accepting while the output side
    // spends extra cycles on check bytes or waits on a stalled receiver.
    bcf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // The output side steps through the results of the head item and frees the
    // queue entry with the last of them.
    bcf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_item),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_is_check_byte (o_is_check_byte),
        .o_run_last      (o_run_last),
        .o_frame_last    (o_frame_last)
    );

endmodule
